### src/text_console_cursor_engine_unit_defines.svh
// ----------------------------------------------------------------------------
// Text console cursor engine: assertion macros
// Shared concurrent assertion wrappers; define ASSERT_OFF to drop them.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CURSOR_ENGINE_UNIT_DEFINES_SVH
`define TEXT_CONSOLE_CURSOR_ENGINE_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// property must hold on every clock edge out of reset
`define TCCE_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("tcce assertion failed");
// when ante holds, cons must hold in the same cycle
`define TCCE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tcce assertion failed");
`else
`define TCCE_ASSERT(label, clk, rst_n, prop)
`define TCCE_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`endif

`endif

### src/tcce_pkg.sv
// ----------------------------------------------------------------------------
// Text console cursor engine package
// Shared types, codes and constants of the cursor engine.
// ----------------------------------------------------------------------------
package tcce_pkg;

	// operation codes
	localparam logic [1:0] OP_PUT  = 2'd0;
	localparam logic [1:0] OP_SET  = 2'd1;
	localparam logic [1:0] OP_MOVE = 2'd2;

	// character codes
	localparam logic [7:0] CH_BACKSPACE = 8'h08;
	localparam logic [7:0] CH_TAB       = 8'h09;
	localparam logic [7:0] CH_NEWLINE   = 8'h0A;
	localparam logic [7:0] CH_SPACE     = 8'h20;
	localparam logic [7:0] CH_PRINT_HI  = 8'h7F;

	// geometry
	localparam int          TCCE_LINE_PITCH  = 80;
	localparam int          TCCE_QUEUE_DEPTH = 4;
	localparam int          TAB_STOP         = 8;
	localparam logic [7:0]  COLUMNS_RESET    = 8'd80;
	localparam logic [6:0]  LINES_RESET      = 7'd25;
	localparam logic [7:0]  COLUMNS_MAX      = 8'd128;
	localparam logic [6:0]  LINES_MAX        = 7'd64;

	// configuration register indexes
	localparam logic CFG_COLUMNS = 1'b0;
	localparam logic CFG_LINES   = 1'b1;

	// command class decided by the front end
	typedef enum logic [2:0] {
		KIND_PRINT   = 3'd0,
		KIND_NEWLINE = 3'd1,
		KIND_TAB     = 3'd2,
		KIND_BKSP    = 3'd3,
		KIND_SET     = 3'd4,
		KIND_MOVE    = 3'd5,
		KIND_NOP     = 3'd6
	} kind_t;

	typedef struct packed {
		kind_t              kind;
		logic [7:0]         ch;
		logic signed [7:0]  x_arg;
		logic signed [6:0]  y_arg;
	} cmd_t;

endpackage

### src/tcce_front.sv
// ----------------------------------------------------------------------------
// Cursor engine front end
// Accept input items and classify them into commands for the queue.
// ----------------------------------------------------------------------------
module tcce_front (
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        op,
	input  logic [7:0]        ch,
	input  logic signed [7:0] x_arg,
	input  logic signed [6:0] y_arg,
	input  logic              q_full,
	output logic              q_push,
	output tcce_pkg::cmd_t    q_cmd
);
	import tcce_pkg::*;

	kind_t kind;

	assign in_stall = q_full;
	assign q_push   = in_valid && !q_full;

	always_comb begin
		kind = KIND_NOP;
		unique case (op)
			OP_PUT: begin
				if (ch >= CH_SPACE && ch <= CH_PRINT_HI) begin
					kind = KIND_PRINT;
				end else if (ch == CH_NEWLINE) begin
					kind = KIND_NEWLINE;
				end else if (ch == CH_TAB) begin
					kind = KIND_TAB;
				end else if (ch == CH_BACKSPACE) begin
					kind = KIND_BKSP;
				end else begin
					kind = KIND_NOP;
				end
			end
			OP_SET:  kind = KIND_SET;
			OP_MOVE: kind = KIND_MOVE;
			default: kind = KIND_NOP;
		endcase
	end

	always_comb begin
		q_cmd.kind  = kind;
		q_cmd.ch    = ch;
		q_cmd.x_arg = x_arg;
		q_cmd.y_arg = y_arg;
	end

endmodule

### src/tcce_queue.sv
// ----------------------------------------------------------------------------
// Cursor engine command queue
// Small flop FIFO between the front end and the back end.
// ----------------------------------------------------------------------------
`include "text_console_cursor_engine_unit_defines.svh"

module tcce_queue #(
	parameter int DEPTH = tcce_pkg::TCCE_QUEUE_DEPTH   // 2 or more
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  tcce_pkg::cmd_t push_cmd,
	output logic           full,
	input  logic           pop,
	output tcce_pkg::cmd_t head_cmd,
	output logic           empty
);
	import tcce_pkg::*;

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	cmd_t          slot_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full     = (count_q == CW'(DEPTH));
	assign empty    = (count_q == '0);
	assign head_cmd = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	`TCCE_ASSERT(a_count_bound, clk, arst_n, count_q <= CW'(DEPTH))
	`TCCE_ASSERT_IMPL(a_no_pop_empty, clk, arst_n, pop, !empty)
	`TCCE_ASSERT_IMPL(a_count_up, clk, arst_n, $past(arst_n) && $past(push && !pop), count_q == $past(count_q) + 1'b1)

endmodule

### src/tcce_back.sv
// ----------------------------------------------------------------------------
// Cursor engine back end
// Apply queued commands to the cursor and register one result per command.
// ----------------------------------------------------------------------------
`include "text_console_cursor_engine_unit_defines.svh"

module tcce_back #(
	parameter int LINE_PITCH = tcce_pkg::TCCE_LINE_PITCH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [7:0]     cols,
	input  logic [6:0]     rows,
	input  logic           q_empty,
	input  tcce_pkg::cmd_t q_cmd,
	output logic           q_pop,
	output logic           out_valid,
	input  logic           out_stall,
	output logic           cell_write,
	output logic [12:0]    cell_address,
	output logic [7:0]     cell_char,
	output logic           scroll_request,
	output logic [6:0]     cursor_col,
	output logic [5:0]     cursor_row,
	output logic [12:0]    cursor_address
);
	import tcce_pkg::*;

	function automatic logic [12:0] addr_of(logic [6:0] x, logic [5:0] y);
		addr_of = 13'(x) + 13'(y) * 13'(LINE_PITCH);
	endfunction

	logic [6:0] cur_col_q;
	logic [5:0] cur_row_q;
	logic       out_valid_q;

	logic [6:0] cols_m1;
	logic [5:0] rows_m1;
	logic [6:0] col0;
	logic [5:0] row0;
	logic [7:0] col_inc;
	logic [7:0] col_tab;
	logic [8:0] sum_x;
	logic [7:0] sum_y;
	logic [5:0] row_adv;
	logic       row_scroll;

	logic [6:0] col_n;
	logic [5:0] row_n;
	logic       wr_n;
	logic [6:0] wcol;
	logic [5:0] wrow;
	logic [7:0] wchar_n;
	logic       scroll_n;

	// clamp the held cursor into the current screen first
	assign cols_m1 = 7'(cols - 8'd1);
	assign rows_m1 = 6'(rows - 7'd1);
	assign col0    = (cur_col_q > cols_m1) ? cols_m1 : cur_col_q;
	assign row0    = (cur_row_q > rows_m1) ? rows_m1 : cur_row_q;

	assign col_inc = {1'b0, col0} + 8'd1;
	assign col_tab = {1'b0, col0[6:3], 3'b000} + 8'(TAB_STOP);
	assign sum_x   = {2'b00, col0} + {q_cmd.x_arg[7], q_cmd.x_arg};
	assign sum_y   = {2'b00, row0} + {q_cmd.y_arg[6], q_cmd.y_arg};

	// next row on line feed or wrap; bottom row holds and asks for a scroll
	assign row_scroll = (row0 == rows_m1);
	assign row_adv    = row_scroll ? rows_m1 : row0 + 6'd1;

	always_comb begin
		col_n    = col0;
		row_n    = row0;
		wr_n     = 1'b0;
		wcol     = col0;
		wrow     = row0;
		wchar_n  = q_cmd.ch;
		scroll_n = 1'b0;
		unique case (q_cmd.kind)
			KIND_PRINT: begin
				wr_n = 1'b1;
				if (col_inc >= cols) begin
					col_n    = '0;
					row_n    = row_adv;
					scroll_n = row_scroll;
				end else begin
					col_n = col_inc[6:0];
				end
			end
			KIND_NEWLINE: begin
				col_n    = '0;
				row_n    = row_adv;
				scroll_n = row_scroll;
			end
			KIND_TAB: begin
				if (col_tab >= cols) begin
					col_n    = '0;
					row_n    = row_adv;
					scroll_n = row_scroll;
				end else begin
					col_n = col_tab[6:0];
				end
			end
			KIND_BKSP: begin
				if (col0 == '0) begin
					if (row0 != '0) begin
						col_n = cols_m1;
						row_n = row0 - 6'd1;
					end
				end else begin
					col_n = col0 - 7'd1;
				end
				wr_n    = 1'b1;
				wcol    = col_n;
				wrow    = row_n;
				wchar_n = CH_SPACE;
			end
			KIND_SET: begin
				if (q_cmd.x_arg[7]) begin
					col_n = '0;
				end else if (q_cmd.x_arg[6:0] > cols_m1) begin
					col_n = cols_m1;
				end else begin
					col_n = q_cmd.x_arg[6:0];
				end
				if (q_cmd.y_arg[6]) begin
					row_n = '0;
				end else if (q_cmd.y_arg[5:0] > rows_m1) begin
					row_n = rows_m1;
				end else begin
					row_n = q_cmd.y_arg[5:0];
				end
			end
			KIND_MOVE: begin
				if (sum_x[8]) begin
					col_n = '0;
				end else if (sum_x[7:0] > {1'b0, cols_m1}) begin
					col_n = cols_m1;
				end else begin
					col_n = sum_x[6:0];
				end
				if (sum_y[7]) begin
					row_n = '0;
				end else if (sum_y[6:0] > {1'b0, rows_m1}) begin
					row_n = rows_m1;
				end else begin
					row_n = sum_y[5:0];
				end
			end
			default: begin
				col_n = col0;
				row_n = row0;
			end
		endcase
	end

	assign q_pop = !q_empty && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_col_q   <= '0;
			cur_row_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				cur_col_q   <= col_n;
				cur_row_q   <= row_n;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cell_write     <= wr_n;
			cell_address   <= wr_n ? addr_of(wcol, wrow) : '0;
			cell_char      <= wr_n ? wchar_n : '0;
			scroll_request <= scroll_n;
			cursor_col     <= col_n;
			cursor_row     <= row_n;
			cursor_address <= addr_of(col_n, row_n);
		end
	end

	assign out_valid = out_valid_q;

	`TCCE_ASSERT_IMPL(a_idle_cell, clk, arst_n, out_valid_q && !cell_write, cell_address == '0 && cell_char == '0)
	`TCCE_ASSERT_IMPL(a_scroll_home, clk, arst_n, out_valid_q && scroll_request, cursor_col == '0)
	`TCCE_ASSERT_IMPL(a_char_range, clk, arst_n, out_valid_q && cell_write, cell_char >= CH_SPACE && cell_char <= CH_PRINT_HI)

endmodule

### src/text_console_cursor_engine_unit.sv
// Text console cursor engine.
// Input channel (in_valid / in_stall): one command per transfer, op with ch,
// x_arg and y_arg. Output channel (out_valid / out_stall): one result per
// command, in order: the cell write (address, character), the scroll request
// and the cursor position and address after the command.
// Configuration channel (cfg_valid / cfg_ready): cfg_index 0 writes columns,
// 1 writes lines; always ready. The user must write them only while the engine
// is idle; the block does not enforce this. A command goes into the queue,
// then the back end takes it from the queue head into the output register.
// Throughput: one command per cycle sustained while out_stall is low; the back
// end's cursor update is combinational on the state left by the last command.
// Reset: cursor at home (0,0), 80 columns by 25 lines, queue and output empty.
// Output stall: the result holds; the queue absorbs up to QUEUE_DEPTH further
// commands, then in_stall rises until the receiver takes a result.
// ----------------------------------------------------------------------------
// Text console cursor engine top level
// Front end, command queue, back end and configuration registers.
// ----------------------------------------------------------------------------
module text_console_cursor_engine_unit #(
	parameter int LINE_PITCH  = tcce_pkg::TCCE_LINE_PITCH,   // 16..128
	parameter int QUEUE_DEPTH = tcce_pkg::TCCE_QUEUE_DEPTH   // 2 or more
) (
	input  logic              clk,
	input  logic              arst_n,
	// configuration
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic              cfg_index,
	input  logic [7:0]        cfg_data,
	// commands
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        op,
	input  logic [7:0]        ch,
	input  logic signed [7:0] x_arg,
	input  logic signed [6:0] y_arg,
	// results
	output logic              out_valid,
	input  logic              out_stall,
	output logic              cell_write,
	output logic [12:0]       cell_address,
	output logic [7:0]        cell_char,
	output logic              scroll_request,
	output logic [6:0]        cursor_col,
	output logic [5:0]        cursor_row,
	output logic [12:0]       cursor_address
);
	import tcce_pkg::*;

	logic [7:0] cols_q;
	logic [6:0] rows_q;

	logic       q_push;
	logic       q_pop;
	logic       q_full;
	logic       q_empty;
	cmd_t       push_cmd;
	cmd_t       head_cmd;

	// registers are always free to take a transfer
	assign cfg_ready = 1'b1;

	// hold geometry already clamped into its legal range
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= COLUMNS_RESET;
			rows_q <= LINES_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_COLUMNS: begin
					if (cfg_data == '0) begin
						cols_q <= 8'd1;
					end else if (cfg_data > COLUMNS_MAX) begin
						cols_q <= COLUMNS_MAX;
					end else begin
						cols_q <= cfg_data;
					end
				end
				CFG_LINES: begin
					if (cfg_data[6:0] == '0) begin
						rows_q <= 7'd1;
					end else if (cfg_data[6:0] > LINES_MAX) begin
						rows_q <= LINES_MAX;
					end else begin
						rows_q <= cfg_data[6:0];
					end
				end
				default: begin
					cols_q <= cols_q;
				end
			endcase
		end
	end

	// classify commands and push them while the queue has room
	tcce_front u_front (
		.in_valid (in_valid),
		.in_stall (in_stall),
		.op       (op),
		.ch       (ch),
		.x_arg    (x_arg),
		.y_arg    (y_arg),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_cmd    (push_cmd)
	);

	// decouple acceptance from the cursor update
	tcce_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop      (q_pop),
		.head_cmd (head_cmd),
		.empty    (q_empty)
	);

	// advance the cursor and register the result
	tcce_back #(
		.LINE_PITCH (LINE_PITCH)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cols           (cols_q),
		.rows           (rows_q),
		.q_empty        (q_empty),
		.q_cmd          (head_cmd),
		.q_pop          (q_pop),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.cell_write     (cell_write),
		.cell_address   (cell_address),
		.cell_char      (cell_char),
		.scroll_request (scroll_request),
		.cursor_col     (cursor_col),
		.cursor_row     (cursor_row),
		.cursor_address (cursor_address)
	);

endmodule
